/* rtl/odbc_pkg.sv */
// Shared constants, codes and types of the ordered dither colorcube block.
// Used by odbc_front, odbc_queue, odbc_back and the top level; no dependencies.
package odbc_pkg;

    localparam int MAX_BANDS   = 4;
    localparam int MAX_MASK_W  = 16;
    localparam int MAX_MASK_H  = 16;
    localparam int PLANE_SIZE  = MAX_MASK_W * MAX_MASK_H;

    localparam int BAND_W      = 2;
    localparam int POS_W       = 8;
    localparam int VALUE_W     = 8;
    localparam int COORD_W     = 16;
    localparam int DIGIT_W     = 4;
    localparam int MOD_STAGES  = COORD_W / DIGIT_W;
    localparam int DIM_W       = 5;
    localparam int COUNT_W     = 3;
    localparam int FMT_W       = 2;
    localparam int MULT_W      = 16;
    localparam int SUM_W       = 32;
    localparam int OUT_W       = 16;
    localparam int CFG_W       = 64;
    localparam int IDX_W       = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        MODE_LOAD  = 1'b0,
        MODE_PIXEL = 1'b1
    } mode_t;

    typedef enum logic [IDX_W-1:0]
    {
        REG_BAND_COUNT  = 3'd0,
        REG_CUBE_OFFSET = 3'd1,
        REG_MULTIPLIERS = 3'd2,
        REG_DIMS        = 3'd3,
        REG_MASK_WIDTH  = 3'd4,
        REG_MASK_HEIGHT = 3'd5,
        REG_OUT_FORMAT  = 3'd6
    } reg_idx_t;

    typedef enum logic [FMT_W-1:0]
    {
        FMT_NONZERO = 2'd0,
        FMT_U8      = 2'd1,
        FMT_S16     = 2'd2
    } fmt_t;

    // One queued request: a mask load or a classified pixel with its mask position.
    typedef struct packed
    {
        mode_t                mode;
        logic [MAX_BANDS-1:0] bits;
        logic [BAND_W-1:0]    band;
        logic [POS_W-1:0]     addr;
        logic [VALUE_W-1:0]   value;
    } q_item_t;

    typedef struct packed
    {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } cfg_front_t;

    typedef struct packed
    {
        logic [COUNT_W-1:0] band_count;
        logic [SUM_W-1:0]   cube_offset;
        logic [CFG_W-1:0]   mults;
        logic [CFG_W-1:0]   dims;
        logic [FMT_W-1:0]   out_format;
    } cfg_back_t;

endpackage

/* rtl/odbc_front.sv */
// Front end: accepts requests, reduces column and row modulo the mask size
// one digit per stage, and pushes classified requests into the queue. Uses odbc_pkg.
module odbc_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  odbc_pkg::cfg_front_t          cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [odbc_pkg::MAX_BANDS-1:0] pixel_bits,
    input  logic [odbc_pkg::COORD_W-1:0]  column,
    input  logic [odbc_pkg::COORD_W-1:0]  row_pos,
    input  logic [odbc_pkg::BAND_W-1:0]   mask_band,
    input  logic [odbc_pkg::POS_W-1:0]    mask_addr,
    input  logic [odbc_pkg::VALUE_W-1:0]  mask_value,
    input  logic                          q_full,
    output logic                          push,
    output odbc_pkg::q_item_t             push_item
);
    import odbc_pkg::*;

    typedef struct packed
    {
        mode_t                mode;
        logic [MAX_BANDS-1:0] bits;
        logic [BAND_W-1:0]    band;
        logic [POS_W-1:0]     addr;
        logic [VALUE_W-1:0]   value;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
        logic [DIM_W-1:0]     rrow;
        logic [DIM_W-1:0]     rcol;
    } fe_stage_t;

    // Restoring remainder over one digit, MSB first; r_in stays below d.
    function automatic logic [DIM_W-1:0] mod_digit(input logic [DIM_W-1:0] r_in,
                                                   input logic [DIGIT_W-1:0] dig,
                                                   input logic [DIM_W-1:0] d);
        logic [DIM_W:0] t;
        t = {1'b0, r_in};
        for (int j = DIGIT_W - 1; j >= 0; j--)
        begin
            t = {t[DIM_W-1:0], dig[j]};
            if (t >= {1'b0, d})
            begin
                t = t - {1'b0, d};
            end
        end
        return t[DIM_W-1:0];
    endfunction

    fe_stage_t                stage_reg  [MOD_STAGES];
    fe_stage_t                stage_next [MOD_STAGES];
    logic [MOD_STAGES-1:0]    valid_reg;
    logic                     adv;
    logic [2*DIM_W-1:0]       row_base;

    assign adv      = !(valid_reg[MOD_STAGES-1] && q_full);
    assign in_stall = !adv;
    assign push     = valid_reg[MOD_STAGES-1] && adv;

    always_comb
    begin
        stage_next[0].mode  = mode_t'(mode);
        stage_next[0].bits  = pixel_bits;
        stage_next[0].band  = mask_band;
        stage_next[0].addr  = mask_addr;
        stage_next[0].value = mask_value;
        stage_next[0].row   = row_pos;
        stage_next[0].col   = column;
        stage_next[0].rrow  = mod_digit('0, row_pos[COORD_W-1 -: DIGIT_W], cfg.height);
        stage_next[0].rcol  = mod_digit('0, column[COORD_W-1 -: DIGIT_W], cfg.width);
        for (int i = 1; i < MOD_STAGES; i++)
        begin
            stage_next[i]      = stage_reg[i-1];
            stage_next[i].rrow = mod_digit(stage_reg[i-1].rrow,
                                           stage_reg[i-1].row[COORD_W-1-DIGIT_W*i -: DIGIT_W],
                                           cfg.height);
            stage_next[i].rcol = mod_digit(stage_reg[i-1].rcol,
                                           stage_reg[i-1].col[COORD_W-1-DIGIT_W*i -: DIGIT_W],
                                           cfg.width);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[MOD_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < MOD_STAGES; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    // Mask position = (row mod h) * w + (col mod w); loads keep their address.
    assign row_base = (2*DIM_W)'(stage_reg[MOD_STAGES-1].rrow) * (2*DIM_W)'(cfg.width);

    always_comb
    begin
        push_item.mode  = stage_reg[MOD_STAGES-1].mode;
        push_item.bits  = stage_reg[MOD_STAGES-1].bits;
        push_item.band  = stage_reg[MOD_STAGES-1].band;
        push_item.value = stage_reg[MOD_STAGES-1].value;
        if (stage_reg[MOD_STAGES-1].mode == MODE_PIXEL)
        begin
            push_item.addr = row_base[POS_W-1:0]
                           + {{(POS_W-DIM_W){1'b0}}, stage_reg[MOD_STAGES-1].rcol};
        end
        else
        begin
            push_item.addr = stage_reg[MOD_STAGES-1].addr;
        end
    end

endmodule

/* rtl/odbc_queue.sv */
// Short request queue between front and back end, held in flip-flops.
// Uses odbc_pkg for the entry type and depth.
module odbc_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  odbc_pkg::q_item_t push_item,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output odbc_pkg::q_item_t head_item
);
    import odbc_pkg::*;

    q_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/odbc_back.sv */
// Back end: mask store per band, threshold compare, index accumulation and
// output formatting, with the output register at its end. Uses odbc_pkg.
module odbc_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  odbc_pkg::cfg_back_t        cfg,
    input  logic                       q_empty,
    input  odbc_pkg::q_item_t          head_item,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [odbc_pkg::OUT_W-1:0] dest_value
);
    import odbc_pkg::*;

    localparam int HALF = MAX_BANDS / 2;

    logic                 be;
    logic                 is_pixel;
    logic [VALUE_W-1:0]   thr_reg  [MAX_BANDS];
    logic [SUM_W-1:0]     prod_reg [MAX_BANDS];
    logic [SUM_W-1:0]     term_reg [MAX_BANDS];
    logic [SUM_W-1:0]     term_next[MAX_BANDS];
    logic [MAX_BANDS-1:0] b1_bits_reg;
    logic [3:0]           valid_reg;
    logic [SUM_W-1:0]     lo_reg, hi_reg, lo_next, hi_next;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     index_sum;
    logic [OUT_W-1:0]     dest_reg, dest_next;
    logic                 out_valid_reg;

    // Advance the whole back end while the output register is free or being taken.
    assign be        = !out_valid_reg || !out_stall;
    assign pop       = be && !q_empty;
    assign is_pixel  = (head_item.mode == MODE_PIXEL);
    assign out_valid = out_valid_reg;
    assign dest_value = dest_reg;

    for (genvar k = 0; k < MAX_BANDS; k++)
    begin : g_band
        logic [VALUE_W-1:0] mem [PLANE_SIZE];

        always_ff @(posedge clk)
        begin
            if (pop && !is_pixel && head_item.band == BAND_W'(k))
            begin
                mem[head_item.addr] <= head_item.value;
            end
            if (pop && is_pixel)
            begin
                thr_reg[k] <= mem[head_item.addr];
            end
        end

        // Base product (dims >> 1) * mult follows the configuration registers.
        always_ff @(posedge clk)
        begin
            prod_reg[k] <= SUM_W'($signed({1'b0, cfg.dims[MULT_W*k+1 +: MULT_W-1]}))
                         * SUM_W'($signed(cfg.mults[MULT_W*k +: MULT_W]));
        end
    end

    always_comb
    begin
        logic [SUM_W-1:0] mult_ext;
        logic             gt;
        for (int k = 0; k < MAX_BANDS; k++)
        begin
            mult_ext = {{(SUM_W-MULT_W){cfg.mults[MULT_W*k+MULT_W-1]}},
                        cfg.mults[MULT_W*k +: MULT_W]};
            gt = cfg.dims[MULT_W*k] && (thr_reg[k] == '0);
            if (b1_bits_reg[k] && (cfg.band_count > COUNT_W'(k)))
            begin
                term_next[k] = prod_reg[k] + (gt ? mult_ext : '0);
            end
            else
            begin
                term_next[k] = '0;
            end
        end
    end

    always_comb
    begin
        lo_next = '0;
        hi_next = '0;
        for (int k = 0; k < MAX_BANDS; k++)
        begin
            if (k < HALF)
            begin
                lo_next = lo_next + term_reg[k];
            end
            else
            begin
                hi_next = hi_next + term_reg[k];
            end
        end
    end

    assign index_sum = sum_reg + cfg.cube_offset;

    always_comb
    begin
        case (cfg.out_format)
            FMT_NONZERO: dest_next = {{(OUT_W-1){1'b0}}, |index_sum};
            FMT_U8:      dest_next = {{(OUT_W-8){1'b0}}, index_sum[7:0]};
            default:     dest_next = index_sum[OUT_W-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (be)
        begin
            valid_reg     <= {valid_reg[2:0], pop && is_pixel};
            out_valid_reg <= valid_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            b1_bits_reg <= head_item.bits;
            for (int k = 0; k < MAX_BANDS; k++)
            begin
                term_reg[k] <= term_next[k];
            end
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            sum_reg  <= lo_reg + hi_reg;
            dest_reg <= dest_next;
        end
    end

endmodule

/* rtl/ordered_dither_bit_to_colorcube.sv */
// Top level of the ordered dither colorcube block: configuration registers,
// front end, request queue and back end. Uses odbc_pkg, odbc_front, odbc_queue, odbc_back.

// Ordered dither of a 1-bit multi-band pixel into a colorcube index. Each accepted
// request is either a mask load (mode 0), which writes one threshold into the
// mask store of its band and gives no result, or a pixel (mode 1), which gives
// exactly one dest_value. One request is accepted every cycle while in_stall is
// low. A pixel passes through the front end, which reduces column and row modulo
// the mask size one 4-bit digit per stage, then the request queue, then the back
// end's mask read, per-band term, two-level add tree, and offset add into the
// output register. Loads take the same path as pixels, so a pixel always sees
// every load requested before it. The back end holds as a whole while a result
// waits to be taken; the queue keeps the front end taking requests until it
// fills. Configuration is written through cfg_write, cfg_index and cfg_data.
// The user must write it only while the block is idle; nothing enforces this.
module ordered_dither_bit_to_colorcube
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [odbc_pkg::IDX_W-1:0]          cfg_index,
    input  logic [odbc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic [odbc_pkg::MAX_BANDS-1:0]      pixel_bits,
    input  logic [odbc_pkg::COORD_W-1:0]        column,
    input  logic [odbc_pkg::COORD_W-1:0]        row_pos,
    input  logic [odbc_pkg::BAND_W-1:0]         mask_band,
    input  logic [odbc_pkg::POS_W-1:0]          mask_addr,
    input  logic [odbc_pkg::VALUE_W-1:0]        mask_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [odbc_pkg::OUT_W-1:0]   dest_value
);
    import odbc_pkg::*;

    logic [COUNT_W-1:0] band_count_reg;
    logic [SUM_W-1:0]   cube_offset_reg;
    logic [CFG_W-1:0]   mults_reg;
    logic [CFG_W-1:0]   dims_reg;
    logic [DIM_W-1:0]   mask_width_reg;
    logic [DIM_W-1:0]   mask_height_reg;
    logic [FMT_W-1:0]   out_format_reg;

    cfg_front_t cfg_front;
    cfg_back_t  cfg_back;
    logic       q_full;
    logic       q_empty;
    logic       push;
    logic       pop;
    q_item_t    push_item;
    q_item_t    head_item;

    // Register file; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_count_reg  <= COUNT_W'(1);
            cube_offset_reg <= '0;
            mults_reg       <= '0;
            dims_reg        <= '0;
            mask_width_reg  <= DIM_W'(1);
            mask_height_reg <= DIM_W'(1);
            out_format_reg  <= FMT_U8;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BAND_COUNT:  band_count_reg  <= cfg_data[COUNT_W-1:0];
                REG_CUBE_OFFSET: cube_offset_reg <= cfg_data[SUM_W-1:0];
                REG_MULTIPLIERS: mults_reg       <= cfg_data;
                REG_DIMS:        dims_reg        <= cfg_data;
                REG_MASK_WIDTH:  mask_width_reg  <= cfg_data[DIM_W-1:0];
                REG_MASK_HEIGHT: mask_height_reg <= cfg_data[DIM_W-1:0];
                REG_OUT_FORMAT:  out_format_reg  <= cfg_data[FMT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Clamp mask size: zero reads as one, anything past the maximum saturates.
    always_comb
    begin
        if (mask_width_reg == '0)
            cfg_front.width = DIM_W'(1);
        else if (mask_width_reg > DIM_W'(MAX_MASK_W))
            cfg_front.width = DIM_W'(MAX_MASK_W);
        else
            cfg_front.width = mask_width_reg;

        if (mask_height_reg == '0)
            cfg_front.height = DIM_W'(1);
        else if (mask_height_reg > DIM_W'(MAX_MASK_H))
            cfg_front.height = DIM_W'(MAX_MASK_H);
        else
            cfg_front.height = mask_height_reg;
    end

    // Band counts past the maximum need no clamp: the back end compares per band.
    assign cfg_back.band_count  = band_count_reg;
    assign cfg_back.cube_offset = cube_offset_reg;
    assign cfg_back.mults       = mults_reg;
    assign cfg_back.dims        = dims_reg;
    assign cfg_back.out_format  = out_format_reg;

    odbc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_front),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .pixel_bits (pixel_bits),
        .column     (column),
        .row_pos    (row_pos),
        .mask_band  (mask_band),
        .mask_addr  (mask_addr),
        .mask_value (mask_value),
        .q_full     (q_full),
        .push       (push),
        .push_item  (push_item)
    );

    odbc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head_item (head_item)
    );

    odbc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_back),
        .q_empty    (q_empty),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .dest_value (dest_value)
    );

endmodule

/* test/odbc_dither_checker.sv */
// Scoreboard for the ordered dither colorcube block: mirrors the configuration
// writes and the mask store, predicts each dest_value and compares it in order.
// Depends on odbc_pkg for widths, register indexes, request modes and formats.
module odbc_dither_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [odbc_pkg::IDX_W-1:0]           cfg_index,
    input  logic [odbc_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic                                 mode,
    input  logic [odbc_pkg::MAX_BANDS-1:0]       pixel_bits,
    input  logic [odbc_pkg::COORD_W-1:0]         column,
    input  logic [odbc_pkg::COORD_W-1:0]         row_pos,
    input  logic [odbc_pkg::BAND_W-1:0]          mask_band,
    input  logic [odbc_pkg::POS_W-1:0]           mask_addr,
    input  logic [odbc_pkg::VALUE_W-1:0]         mask_value,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [odbc_pkg::OUT_W-1:0]    dest_value,
    output int                                   mismatch_count,
    output int                                   outstanding
);
    import odbc_pkg::*;

    logic [COUNT_W-1:0] band_count_r;
    logic [SUM_W-1:0]   offset_r;
    logic [CFG_W-1:0]   mults_r;
    logic [CFG_W-1:0]   dims_r;
    logic [DIM_W-1:0]   width_r;
    logic [DIM_W-1:0]   height_r;
    logic [FMT_W-1:0]   format_r;
    logic [VALUE_W-1:0] thresholds [MAX_BANDS][PLANE_SIZE];
    logic [OUT_W-1:0]   expected_values [$];
    int                 fail_tally;

    // Colorcube index of one pixel under the current settings and mask contents.
    function automatic logic [OUT_W-1:0] dither_index
    (
        input logic [MAX_BANDS-1:0] bits,
        input logic [COORD_W-1:0]   col,
        input logic [COORD_W-1:0]   row
    );
        int unsigned        w;
        int unsigned        h;
        int unsigned        nb;
        int unsigned        pos;
        logic [SUM_W-1:0]   sum;
        logic [SUM_W-1:0]   mult;
        logic [MULT_W-1:0]  dims;
        logic [VALUE_W-1:0] thr;
        w   = (width_r == '0) ? 1
            : ((int'(width_r) > MAX_MASK_W) ? MAX_MASK_W : int'(width_r));
        h   = (height_r == '0) ? 1
            : ((int'(height_r) > MAX_MASK_H) ? MAX_MASK_H : int'(height_r));
        nb  = (int'(band_count_r) > MAX_BANDS) ? MAX_BANDS : int'(band_count_r);
        pos = (32'(row) % h) * w + (32'(col) % w);
        sum = offset_r;
        for (int k = 0; k < MAX_BANDS; k++)
        begin
            if (k < nb && bits[k])
            begin
                dims = dims_r[MULT_W*k +: MULT_W];
                mult = {{(SUM_W-MULT_W){mults_r[MULT_W*k+MULT_W-1]}},
                        mults_r[MULT_W*k +: MULT_W]};
                thr  = thresholds[k][pos];
                sum  = sum + {{(SUM_W-MULT_W+1){1'b0}}, dims[MULT_W-1:1]} * mult;
                if (VALUE_W'(dims[0]) > thr)
                    sum = sum + mult;
            end
        end
        case (format_r)
            FMT_NONZERO: return (sum != 0) ? 16'd1 : 16'd0;
            FMT_U8:      return {8'b0, sum[7:0]};
            default:     return sum[OUT_W-1:0];
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [OUT_W-1:0] want;
        if (!rst_n)
        begin
            band_count_r = 3'd1;
            offset_r     = '0;
            mults_r      = '0;
            dims_r       = '0;
            width_r      = 5'd1;
            height_r     = 5'd1;
            format_r     = FMT_U8;
            for (int b = 0; b < MAX_BANDS; b++)
                for (int a = 0; a < PLANE_SIZE; a++)
                    thresholds[b][a] = '0;
            expected_values.delete();
            fail_tally = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BAND_COUNT:  band_count_r = cfg_data[COUNT_W-1:0];
                    REG_CUBE_OFFSET: offset_r     = cfg_data[SUM_W-1:0];
                    REG_MULTIPLIERS: mults_r      = cfg_data;
                    REG_DIMS:        dims_r       = cfg_data;
                    REG_MASK_WIDTH:  width_r      = cfg_data[DIM_W-1:0];
                    REG_MASK_HEIGHT: height_r     = cfg_data[DIM_W-1:0];
                    REG_OUT_FORMAT:  format_r     = cfg_data[FMT_W-1:0];
                    default: ;
                endcase
            end

            // Retire results before queueing new ones so a stray result never
            // pairs with a pixel taken in the same cycle.
            if (out_valid && !out_stall)
            begin
                if (expected_values.size() == 0)
                begin
                    $error("dest_value with nothing pending: actual %0d", dest_value);
                    fail_tally++;
                end
                else
                begin
                    want = expected_values.pop_front();
                    if (want !== dest_value)
                    begin
                        $error("dest_value mismatch: expected %0d, actual %0d",
                               $signed(want), dest_value);
                        fail_tally++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (mode == MODE_LOAD)
                    thresholds[mask_band][mask_addr] = mask_value;
                else
                    expected_values.push_back(dither_index(pixel_bits, column, row_pos));
            end
        end
        mismatch_count <= fail_tally;
        outstanding    <= expected_values.size();
    end

endmodule

/* test/tb_top.sv */
// Top of the ordered dither colorcube regression: clock, reset, configuration
// phases, request stimulus and the verdict. Depends on odbc_pkg, the block
// ordered_dither_bit_to_colorcube and the scoreboard odbc_dither_checker.
module tb_top;

    import odbc_pkg::*;

    localparam int LIMIT_CYCLES     = 200000;
    localparam int DRAIN_CYCLES     = 24;   // well past a pixel's latency through the block
    localparam int PRELOAD_SPAN     = 16;   // mask entries per band filled before pixels
    localparam int RANDOM_PER_PHASE = 60;
    localparam int LOAD_SHARE       = 20;   // percent of random requests that are loads

    // Format code three has no name in the package; the block treats it as 16-bit.
    localparam logic [FMT_W-1:0] FMT_ALIAS_S16 = 2'd3;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     cfg_write  = 1'b0;
    logic [IDX_W-1:0]         cfg_index  = REG_BAND_COUNT;
    logic [CFG_W-1:0]         cfg_data   = '0;
    logic                     in_valid   = 1'b0;
    logic                     in_stall;
    logic                     mode       = MODE_LOAD;
    logic [MAX_BANDS-1:0]     pixel_bits = '0;
    logic [COORD_W-1:0]       column     = '0;
    logic [COORD_W-1:0]       row_pos    = '0;
    logic [BAND_W-1:0]        mask_band  = '0;
    logic [POS_W-1:0]         mask_addr  = '0;
    logic [VALUE_W-1:0]       mask_value = '0;
    logic                     out_valid;
    logic                     out_stall  = 1'b0;
    logic signed [OUT_W-1:0]  dest_value;

    int mismatch_count;
    int outstanding;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Effective mask geometry and band count, kept so that pixels only read
    // mask entries that have been loaded.
    int cur_w  = 1;
    int cur_h  = 1;
    int cur_nb = 1;
    bit loaded_map [MAX_BANDS][PLANE_SIZE];

    ordered_dither_bit_to_colorcube dut (.*);

    odbc_dither_checker watch (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at random; the rate changes per phase.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Guard against a hung handshake or a lost result.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // Present one request and hold it until the block takes it. Idle cycles
    // ahead of it drop valid; the payload never changes while stalled.
    task automatic issue_request
    (
        input mode_t                kind,
        input logic [MAX_BANDS-1:0] bits,
        input logic [COORD_W-1:0]   col,
        input logic [COORD_W-1:0]   row,
        input logic [BAND_W-1:0]    band,
        input logic [POS_W-1:0]     addr,
        input logic [VALUE_W-1:0]   value
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= kind;
        pixel_bits <= bits;
        column     <= col;
        row_pos    <= row;
        mask_band  <= band;
        mask_addr  <= addr;
        mask_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (kind == MODE_LOAD)
            loaded_map[band][addr] = 1'b1;
    endtask

    // Hold off new requests until every pending result is back, then let any
    // trailing load clear the pipeline.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register; the caller drops the write enable after the last one.
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_setting
    (
        input logic [COUNT_W-1:0] bands,
        input logic [SUM_W-1:0]   offset,
        input logic [CFG_W-1:0]   mults,
        input logic [CFG_W-1:0]   dims,
        input logic [DIM_W-1:0]   w,
        input logic [DIM_W-1:0]   h,
        input logic [FMT_W-1:0]   fmt
    );
        write_reg(REG_BAND_COUNT, CFG_W'(bands));
        write_reg(REG_CUBE_OFFSET, CFG_W'(offset));
        write_reg(REG_MULTIPLIERS, mults);
        write_reg(REG_DIMS, dims);
        write_reg(REG_MASK_WIDTH, CFG_W'(w));
        write_reg(REG_MASK_HEIGHT, CFG_W'(h));
        write_reg(REG_OUT_FORMAT, CFG_W'(fmt));
        cfg_write <= 1'b0;
        @(posedge clk);
        // Zero sizes read as one, oversize values saturate.
        cur_nb = (int'(bands) > MAX_BANDS) ? MAX_BANDS : int'(bands);
        cur_w  = (w == '0) ? 1 : ((int'(w) > MAX_MASK_W) ? MAX_MASK_W : int'(w));
        cur_h  = (h == '0) ? 1 : ((int'(h) > MAX_MASK_H) ? MAX_MASK_H : int'(h));
    endtask

    // Thresholds of zero and one decide whether the odd-dimension step fires,
    // so favor them heavily.
    function automatic logic [VALUE_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return 8'd0;
        if (r < 6)
            return 8'd1;
        if (r == 6)
            return 8'd255;
        return VALUE_W'($urandom_range(255));
    endfunction

    // Number of mask positions, from the start of each plane, that pixels aim at.
    function automatic int region_span();
        return (cur_w * cur_h < PRELOAD_SPAN) ? cur_w * cur_h : PRELOAD_SPAN;
    endfunction

    // Drop the bit of any band in use whose mask entry at this pixel is unloaded.
    function automatic logic [MAX_BANDS-1:0] legal_bits
    (
        input logic [MAX_BANDS-1:0] bits,
        input int                   col,
        input int                   row
    );
        int                   pos;
        logic [MAX_BANDS-1:0] kept;
        pos  = (row % cur_h) * cur_w + (col % cur_w);
        kept = bits;
        for (int k = 0; k < cur_nb; k++)
            if (!loaded_map[k][pos])
                kept[k] = 1'b0;
        return kept;
    endfunction

    // Fill the leading mask entries of every band that have never been loaded.
    task automatic preload_region();
        int span;
        span = region_span();
        for (int b = 0; b < MAX_BANDS; b++)
            for (int a = 0; a < span; a++)
                if (!loaded_map[b][a])
                    issue_request(MODE_LOAD, MAX_BANDS'($urandom_range(15)),
                                  COORD_W'($urandom_range(65535)),
                                  COORD_W'($urandom_range(65535)),
                                  BAND_W'(b), POS_W'(a), pick_threshold());
    endtask

    // One random request: mostly pixels aimed at loaded mask positions, the rest
    // loads that rewrite thresholds or touch the far reaches of the store.
    task automatic random_request();
        int pick;
        int tgt;
        int col_i;
        int row_i;
        if ($urandom_range(99) < LOAD_SHARE)
        begin
            issue_request(MODE_LOAD, MAX_BANDS'($urandom_range(15)),
                          COORD_W'($urandom_range(65535)),
                          COORD_W'($urandom_range(65535)), BAND_W'($urandom_range(3)),
                          POS_W'($urandom_range(1) ? $urandom_range(PRELOAD_SPAN-1)
                                                   : $urandom_range(255)),
                          pick_threshold());
        end
        else
        begin
            pick = $urandom_range(9);
            if (pick == 0)
            begin
                col_i = $urandom_range(1) * 65535;
                row_i = $urandom_range(1) * 65535;
            end
            else if (pick < 5)
            begin
                col_i = $urandom_range(65535);
                row_i = $urandom_range(65535);
            end
            else
            begin
                // Land on a chosen mask position through an arbitrary tile.
                tgt   = $urandom_range(region_span() - 1);
                col_i = tgt % cur_w + cur_w * $urandom_range((65535 - tgt % cur_w) / cur_w);
                row_i = tgt / cur_w + cur_h * $urandom_range((65535 - tgt / cur_w) / cur_h);
            end
            issue_request(MODE_PIXEL,
                          legal_bits(MAX_BANDS'($urandom_range(15)), col_i, row_i),
                          COORD_W'(col_i), COORD_W'(row_i), BAND_W'($urandom_range(3)),
                          POS_W'($urandom_range(255)), VALUE_W'($urandom_range(255)));
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] lanes_m;
        logic [CFG_W-1:0] lanes_d;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: all four bands on a 2x2 mask with signed extreme
        // multipliers and a mix of odd and even dimensions.
        set_idling(24, 56);
        apply_setting(3'd4, 32'd3, 64'h8000_7FFF_FFFF_0001, 64'hFFFF_0003_0002_0001,
                      5'd2, 5'd2, FMT_S16);
        preload_region();
        // Loads carrying pixel fields, the last entry of the store, value extremes.
        issue_request(MODE_LOAD, 4'hF, 16'hFFFF, 16'hFFFF, 2'd3, 8'd255, 8'd255);
        issue_request(MODE_LOAD, 4'hF, 16'hFFFF, 16'hFFFF, 2'd0, 8'd0, 8'd0);
        issue_request(MODE_LOAD, 4'h0, 16'd0, 16'd0, 2'd1, 8'd3, 8'd255);
        issue_request(MODE_LOAD, 4'h0, 16'd0, 16'd0, 2'd2, 8'd3, 8'd1);
        // Pixels carrying load fields, coordinate extremes, no band set.
        issue_request(MODE_PIXEL, 4'hF, 16'd0, 16'd0, 2'd3, 8'hFF, 8'hFF);
        issue_request(MODE_PIXEL, 4'hF, 16'hFFFF, 16'hFFFF, 2'd3, 8'hFF, 8'hFF);
        issue_request(MODE_PIXEL, 4'h0, 16'd1, 16'd0, 2'd0, 8'd0, 8'd0);
        // One band at a time, at two mask positions.
        for (int k = 0; k < MAX_BANDS; k++)
        begin
            issue_request(MODE_PIXEL, 4'(1 << k), 16'd1, 16'd1, 2'd0, 8'd0, 8'd0);
            issue_request(MODE_PIXEL, 4'(1 << k), 16'd0, 16'd1, 2'd0, 8'd0, 8'd0);
        end
        issue_request(MODE_PIXEL, 4'hA, 16'd2, 16'd3, 2'd0, 8'd0, 8'd0);

        // Random phases, each under its own setting. The receiver idles more in the
        // first phases, the sender in the middle ones, neither at the end.
        for (int phase = 1; phase <= 6; phase++)
        begin
            if (phase == 3)
                set_idling(56, 24);
            if (phase == 5)
                set_idling(0, 0);
            settle();
            lanes_m = {$urandom, $urandom};
            lanes_d = {$urandom, $urandom};
            case (phase)
                // No band in use, zero mask sizes, nonzero test on a zero index.
                1: apply_setting(3'd0, 32'd0, lanes_m, lanes_d, 5'd0, 5'd0, FMT_NONZERO);
                // Band count and mask sizes past the maximum, index wrapping.
                2: apply_setting(3'd7, 32'h7FFF_FFFF, 64'h7FFF_8000_7FFF_8000,
                                 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 5'd17, FMT_ALIAS_S16);
                3: apply_setting(3'd1, 32'h8000_0000, lanes_m, lanes_d, 5'd16, 5'd1,
                                 FMT_U8);
                4: apply_setting(3'd5, $urandom, lanes_m, lanes_d,
                                 DIM_W'($urandom_range(1, 16)),
                                 DIM_W'($urandom_range(1, 16)), FMT_S16);
                // Small terms around zero so the nonzero test flips both ways.
                5:
                begin
                    for (int k = 0; k < MAX_BANDS; k++)
                    begin
                        lanes_m[MULT_W*k +: MULT_W] = 16'($signed($urandom_range(6)) - 3);
                        lanes_d[MULT_W*k +: MULT_W] = MULT_W'($urandom_range(7));
                    end
                    apply_setting(3'd2, 32'($signed($urandom_range(8)) - 4), lanes_m,
                                  lanes_d, 5'd3, 5'd5, FMT_NONZERO);
                end
                default: apply_setting(3'd3, $urandom, lanes_m, lanes_d,
                                       DIM_W'($urandom_range(1, 8)),
                                       DIM_W'($urandom_range(1, 8)), FMT_U8);
            endcase
            preload_region();
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // Starve the block once mid-phase until it has fully drained.
                if (phase == 4 && n == RANDOM_PER_PHASE / 2)
                    settle();
                random_request();
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
rtl/odbc_pkg.sv
rtl/odbc_front.sv
rtl/odbc_queue.sv
rtl/odbc_back.sv
rtl/ordered_dither_bit_to_colorcube.sv
test/odbc_dither_checker.sv
test/tb_top.sv
